@@ rtl/core/pmfd_pkg.sv @@
`default_nettype none

package pmfd_pkg;

    localparam int MAX_BODY_DEF = 1023;
    localparam int STORE_DEPTH  = 60;
    localparam int MIN_BODY     = STORE_DEPTH + 2;

    localparam int VAL_W      = 40;
    localparam int NUM_Q      = 16;
    localparam int QRAM_DEPTH = 2 * NUM_Q;
    localparam int QRAM_AW    = $clog2(QRAM_DEPTH);

    localparam logic [7:0] SYNC_A    = 8'hFE;
    localparam logic [7:0] SYNC_B    = 8'hFF;
    localparam logic [7:0] SUM_SEED  = 8'hFD;
    localparam logic [7:0] DEVICE_ID = 8'h03;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_CSUM  = 3'd1;
    localparam logic [2:0] ST_ID    = 3'd2;
    localparam logic [2:0] ST_LONG  = 3'd3;
    localparam logic [2:0] ST_SHORT = 3'd4;

    localparam logic [3:0] Q_VOLT   = 4'd0;
    localparam logic [3:0] Q_SERIAL = 4'd1;
    localparam logic [3:0] Q_TIME   = 4'd2;
    localparam logic [3:0] Q_CUR_A  = 4'd3;
    localparam logic [3:0] Q_CUR_B  = 4'd4;
    localparam logic [3:0] Q_DC     = 4'd5;
    localparam logic [3:0] Q_EN_A   = 4'd6;
    localparam logic [3:0] Q_EN_B   = 4'd7;
    localparam logic [3:0] Q_PEN_A  = 4'd8;
    localparam logic [3:0] Q_PEN_B  = 4'd9;
    localparam logic [3:0] Q_AUX0   = 4'd10;
    localparam logic [3:0] Q_LAST   = 4'd14;

    localparam logic [1:0] REG_MAX_QUIET = 2'd0;
    localparam logic [1:0] REG_MIN_GAP   = 2'd1;
    localparam logic [1:0] REG_CUR_STEP  = 2'd2;
    localparam logic [1:0] REG_VOLT_STEP = 2'd3;

    localparam logic [15:0] RST_MAX_QUIET = 16'd30;
    localparam logic [15:0] RST_MIN_GAP   = 16'd15;
    localparam logic [15:0] RST_CUR_STEP  = 16'd30;
    localparam logic [15:0] RST_VOLT_STEP = 16'd5;

    typedef struct packed {
        logic       hit;
        logic       first;
        logic       fin;
        logic [3:0] q;
        logic [2:0] lane;
    } t_field;

    typedef struct packed {
        logic                 we;
        logic [QRAM_AW-1:0]   addr;
        logic [VAL_W-1:0]     data;
    } t_qwr;

    typedef struct packed {
        logic [15:0] volt;
        logic [15:0] cur_a;
        logic [15:0] cur_b;
        logic [23:0] tm;
    } t_meas;

    typedef struct packed {
        logic       ok;
        logic       err;
        logic [2:0] status;
        logic       rep;
        logic       bank;
    } t_emit_req;

    typedef struct packed {
        logic busy;
        logic bank;
    } t_emit_sts;

    function automatic t_field mk_field(input logic [3:0] q, input logic first,
                                        input logic fin, input logic [2:0] lane);
        t_field f;
        f.hit   = 1'b1;
        f.first = first;
        f.fin   = fin;
        f.q     = q;
        f.lane  = lane;
        return f;
    endfunction

    // body offset -> quantity slot and byte lane
    function automatic t_field field_of(input logic [5:0] idx);
        t_field     f;
        logic [5:0] aux;
        aux = idx - 6'd38;
        f   = '0;
        if (idx >= 6'd1 && idx <= 6'd2) begin
            f = mk_field(Q_VOLT, idx == 6'd1, idx == 6'd2, 3'(6'd2 - idx));
        end else if (idx >= 6'd3 && idx <= 6'd7) begin
            f = mk_field(Q_EN_A, idx == 6'd3, idx == 6'd7, 3'(idx - 6'd3));
        end else if (idx >= 6'd8 && idx <= 6'd12) begin
            f = mk_field(Q_EN_B, idx == 6'd8, idx == 6'd12, 3'(idx - 6'd8));
        end else if (idx >= 6'd13 && idx <= 6'd17) begin
            f = mk_field(Q_PEN_A, idx == 6'd13, idx == 6'd17, 3'(idx - 6'd13));
        end else if (idx >= 6'd18 && idx <= 6'd22) begin
            f = mk_field(Q_PEN_B, idx == 6'd18, idx == 6'd22, 3'(idx - 6'd18));
        end else if (idx >= 6'd27 && idx <= 6'd28) begin
            f = mk_field(Q_SERIAL, idx == 6'd27, idx == 6'd28, 3'(idx - 6'd27));
        end else if (idx >= 6'd31 && idx <= 6'd32) begin
            f = mk_field(Q_CUR_A, idx == 6'd31, idx == 6'd32, 3'(idx - 6'd31));
        end else if (idx >= 6'd33 && idx <= 6'd34) begin
            f = mk_field(Q_CUR_B, idx == 6'd33, idx == 6'd34, 3'(idx - 6'd33));
        end else if (idx >= 6'd35 && idx <= 6'd37) begin
            f = mk_field(Q_TIME, idx == 6'd35, idx == 6'd37, 3'(idx - 6'd35));
        end else if (idx >= 6'd38 && idx <= 6'd57) begin
            f = mk_field(4'(Q_AUX0 + 4'(aux[4:2])), aux[1:0] == 2'd0,
                         aux[1:0] == 2'd3, {1'b0, aux[1:0]});
        end else if (idx >= 6'd58 && idx <= 6'd59) begin
            f = mk_field(Q_DC, idx == 6'd58, idx == 6'd59, 3'(idx - 6'd58));
        end
        return f;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/pmfd_ram.sv @@
`default_nettype none

module pmfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/core/pmfd_asm.sv @@
`default_nettype none

module pmfd_asm (
    input  wire logic           i_clk,
    input  wire logic           i_en,
    input  wire logic [5:0]     i_idx,
    input  wire logic [7:0]     i_byte,
    input  wire logic           i_wbank,
    output pmfd_pkg::t_qwr      o_wr,
    output pmfd_pkg::t_meas     o_meas
);

    import pmfd_pkg::*;

    t_field           fld;
    logic [VAL_W-1:0] r_acc;
    logic [VAL_W-1:0] n_acc;
    t_meas            r_meas;
    t_meas            n_meas;

    always_comb begin
        fld    = field_of(i_idx);
        n_acc  = (fld.first ? '0 : r_acc) | (VAL_W'(i_byte) << {fld.lane, 3'b000});
        n_meas = r_meas;
        if (i_en && fld.hit && fld.fin) begin
            unique case (fld.q)
                Q_VOLT:  n_meas.volt  = n_acc[15:0];
                Q_CUR_A: n_meas.cur_a = n_acc[15:0];
                Q_CUR_B: n_meas.cur_b = n_acc[15:0];
                Q_TIME:  n_meas.tm    = n_acc[23:0];
                default: n_meas       = r_meas;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && fld.hit) begin
            r_acc <= n_acc;
        end
        r_meas <= n_meas;
    end

    assign o_wr   = {i_en && fld.hit && fld.fin, i_wbank, fld.q, n_acc};
    assign o_meas = r_meas;

endmodule

`default_nettype wire

@@ rtl/core/pmfd_emit.sv @@
`default_nettype none

module pmfd_emit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire pmfd_pkg::t_emit_req           i_req,
    output pmfd_pkg::t_emit_sts                o_sts,
    output logic [pmfd_pkg::QRAM_AW-1:0]       o_raddr,
    input  wire logic [pmfd_pkg::VAL_W-1:0]    i_rdata,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [2:0]                         o_status,
    output logic [3:0]                         o_quantity,
    output logic [pmfd_pkg::VAL_W-1:0]         o_value,
    output logic                               o_report,
    output logic                               o_last
);

    import pmfd_pkg::*;

    logic             r_left;
    logic [3:0]       r_next;
    logic             r_dv;
    logic [3:0]       r_dq;
    logic             r_bank;
    logic             r_rep;
    logic             r_oval;
    logic [2:0]       r_status;
    logic [3:0]       r_quantity;
    logic [VAL_W-1:0] r_value;
    logic             r_report;
    logic             r_last;

    logic             n_left;
    logic [3:0]       n_next;
    logic             n_dv;
    logic [3:0]       n_dq;
    logic             load;
    logic             adv;
    logic [3:0]       rd_q;

    always_comb begin
        load   = r_dv && (!r_oval || !i_stall);
        adv    = !r_dv || load;
        n_left = r_left;
        n_next = r_next;
        n_dv   = r_dv;
        n_dq   = r_dq;
        rd_q   = r_dq;
        if (adv) begin
            rd_q = r_next;
            n_dv = r_left;
            n_dq = r_next;
            if (r_left) begin
                n_next = r_next + 4'd1;
                n_left = (r_next != Q_LAST);
            end
        end
        if (i_req.ok) begin
            n_left = 1'b1;
            n_next = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 1'b0;
            r_next <= '0;
            r_dv   <= 1'b0;
            r_dq   <= '0;
            r_bank <= 1'b0;
            r_rep  <= 1'b0;
            r_oval <= 1'b0;
        end else begin
            r_left <= n_left;
            r_next <= n_next;
            r_dv   <= n_dv;
            r_dq   <= n_dq;
            if (i_req.ok) begin
                r_bank <= i_req.bank;
                r_rep  <= i_req.rep;
            end
            priority if (load || i_req.err) begin
                r_oval <= 1'b1;
            end else if (r_oval && !i_stall) begin
                r_oval <= 1'b0;
            end else begin
                r_oval <= r_oval;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (load) begin
            r_status   <= ST_OK;
            r_quantity <= r_dq;
            r_value    <= i_rdata;
            r_report   <= r_rep;
            r_last     <= (r_dq == Q_LAST);
        end else if (i_req.err) begin
            r_status   <= i_req.status;
            r_quantity <= Q_VOLT;
            r_value    <= '0;
            r_report   <= 1'b0;
            r_last     <= 1'b1;
        end else begin
            r_status   <= r_status;
            r_quantity <= r_quantity;
            r_value    <= r_value;
            r_report   <= r_report;
            r_last     <= r_last;
        end
    end

    assign o_sts      = {r_left || r_dv, r_bank};
    assign o_raddr    = {r_bank, rd_q};
    assign o_valid    = r_oval;
    assign o_status   = r_status;
    assign o_quantity = r_quantity;
    assign o_value    = r_value;
    assign o_report   = r_report;
    assign o_last     = r_last;

endmodule

`default_nettype wire

@@ rtl/core/power_monitor_frame_decoder.sv @@
// channel   direction  handshake                  payload
// rx        in         i_in_valid / o_in_stall    i_rx_byte
// result    out        o_out_valid / i_out_stall  o_status o_quantity o_value o_report o_last
// config    in         psel penable pwrite pready paddr pwdata prdata
//
// One byte per cycle while o_in_stall is low. Body bytes are folded into a two-bank
// quantity RAM as they arrive. A good check byte starts a burst of 15 requests, one per
// cycle while i_out_stall is low, from the RAM read port; an error gives a single request.
// Bytes that may produce a request wait while a burst or a stalled request is pending.
// Synchronous active-low reset; no clearing pass.
`default_nettype none

module power_monitor_frame_decoder #(
    parameter int MAX_BODY = pmfd_pkg::MAX_BODY_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [7:0]                  i_rx_byte,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [2:0]                       o_status,
    output logic [3:0]                       o_quantity,
    output logic [pmfd_pkg::VAL_W-1:0]       o_value,
    output logic                             o_report,
    output logic                             o_last,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [3:0]                  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    import pmfd_pkg::*;

    localparam int CW = $clog2(MAX_BODY + 1);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_BODY,
        PH_CHECK
    } t_phase;

    t_phase       r_phase;
    logic [7:0]   r_last_byte;
    logic [7:0]   r_sum;
    logic [CW-1:0] r_count;
    logic         r_wbank;

    logic [15:0]  r_max_quiet;
    logic [15:0]  r_min_gap;
    logic [15:0]  r_cur_step;
    logic [15:0]  r_volt_step;

    logic [23:0]  r_rep_tm;
    logic [15:0]  r_rep_ca;
    logic [15:0]  r_rep_cb;
    logic [15:0]  r_rep_volt;

    logic          accept;
    logic          needs_out;
    logic [CW-1:0] n_count;
    logic [7:0]    n_sum;
    logic          store_en;
    t_emit_req     req;
    t_emit_sts     emit_sts;
    t_qwr          qwr;
    t_meas         meas;
    logic [QRAM_AW-1:0] raddr;
    logic [VAL_W-1:0]   rdata;
    logic          rep;
    logic [24:0]   quiet_lim;
    logic [24:0]   gap_lim;
    logic [15:0]   d_ca;
    logic [15:0]   d_cb;
    logic [15:0]   d_v;
    logic          cfg_wr;

    // register file
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_quiet <= RST_MAX_QUIET;
            r_min_gap   <= RST_MIN_GAP;
            r_cur_step  <= RST_CUR_STEP;
            r_volt_step <= RST_VOLT_STEP;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_MAX_QUIET: r_max_quiet <= pwdata[15:0];
                REG_MIN_GAP:   r_min_gap   <= pwdata[15:0];
                REG_CUR_STEP:  r_cur_step  <= pwdata[15:0];
                REG_VOLT_STEP: r_volt_step <= pwdata[15:0];
                default:       r_max_quiet <= r_max_quiet;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_MAX_QUIET: prdata = {16'd0, r_max_quiet};
            REG_MIN_GAP:   prdata = {16'd0, r_min_gap};
            REG_CUR_STEP:  prdata = {16'd0, r_cur_step};
            REG_VOLT_STEP: prdata = {16'd0, r_volt_step};
            default:       prdata = '0;
        endcase
    end

    // report thresholds
    always_comb begin
        quiet_lim = {1'b0, r_rep_tm} + 25'(r_max_quiet);
        gap_lim   = {1'b0, r_rep_tm} + 25'(r_min_gap);
        d_ca = (r_rep_ca > meas.cur_a) ? r_rep_ca - meas.cur_a : meas.cur_a - r_rep_ca;
        d_cb = (r_rep_cb > meas.cur_b) ? r_rep_cb - meas.cur_b : meas.cur_b - r_rep_cb;
        d_v  = (r_rep_volt > meas.volt) ? r_rep_volt - meas.volt : meas.volt - r_rep_volt;
        rep  = ({1'b0, meas.tm} > quiet_lim) || (d_ca >= r_cur_step)
            || (d_cb >= r_cur_step) || (d_v >= r_volt_step);
        if (gap_lim >= {1'b0, meas.tm}) begin
            rep = 1'b0;
        end
    end

    // frame sequencer
    always_comb begin
        n_count   = r_count + CW'(1);
        n_sum     = r_sum + i_rx_byte;
        needs_out = (r_phase == PH_CHECK)
            || (r_phase == PH_BODY && (r_count == '0 || n_count >= CW'(MAX_BODY)));
        o_in_stall = needs_out && (emit_sts.busy || (o_out_valid && i_out_stall));
        accept     = i_in_valid && !o_in_stall;
        store_en   = accept && (r_phase == PH_BODY) && (r_count < CW'(STORE_DEPTH));

        req = '0;
        req.rep  = rep;
        req.bank = r_wbank;
        if (accept) begin
            unique case (r_phase)
                PH_BODY: begin
                    if (r_count == '0 && i_rx_byte != DEVICE_ID) begin
                        req.err    = 1'b1;
                        req.status = ST_ID;
                    end else if (n_count >= CW'(MAX_BODY)) begin
                        req.err    = 1'b1;
                        req.status = ST_LONG;
                    end
                end
                PH_CHECK: begin
                    if (i_rx_byte != r_sum) begin
                        req.err    = 1'b1;
                        req.status = ST_CSUM;
                    end else if (r_count < CW'(MIN_BODY)) begin
                        req.err    = 1'b1;
                        req.status = ST_SHORT;
                    end else begin
                        req.ok = 1'b1;
                    end
                end
                default: req.err = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_last_byte <= '0;
            r_sum       <= '0;
            r_count     <= '0;
            r_wbank     <= 1'b0;
            r_rep_tm    <= '0;
            r_rep_ca    <= '0;
            r_rep_cb    <= '0;
            r_rep_volt  <= '0;
        end else begin
            if (accept) begin
                r_last_byte <= i_rx_byte;
                unique case (r_phase)
                    PH_BODY: begin
                        r_sum   <= n_sum;
                        r_count <= n_count;
                        if (req.err) begin
                            r_phase <= PH_HUNT;
                        end else if (r_last_byte == SYNC_B && i_rx_byte == SYNC_A) begin
                            r_phase <= PH_CHECK;
                        end
                    end
                    PH_CHECK: begin
                        r_phase <= PH_HUNT;
                    end
                    default: begin
                        r_phase <= PH_HUNT;
                        if (r_last_byte == SYNC_A && i_rx_byte == SYNC_B) begin
                            r_phase <= PH_BODY;
                            r_sum   <= SUM_SEED;
                            r_count <= '0;
                        end
                    end
                endcase
            end
            if (req.ok) begin
                r_wbank <= !r_wbank;
                if (rep) begin
                    r_rep_tm   <= meas.tm;
                    r_rep_ca   <= meas.cur_a;
                    r_rep_cb   <= meas.cur_b;
                    r_rep_volt <= meas.volt;
                end
            end
        end
    end

    pmfd_asm u_asm (
        .i_clk   (i_clk),
        .i_en    (store_en),
        .i_idx   (r_count[5:0]),
        .i_byte  (i_rx_byte),
        .i_wbank (r_wbank),
        .o_wr    (qwr),
        .o_meas  (meas)
    );

    pmfd_ram #(
        .WIDTH (VAL_W),
        .DEPTH (QRAM_DEPTH)
    ) u_qram (
        .i_clk   (i_clk),
        .i_we    (qwr.we),
        .i_waddr (qwr.addr),
        .i_wdata (qwr.data),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    pmfd_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req),
        .o_sts      (emit_sts),
        .o_raddr    (raddr),
        .i_rdata    (rdata),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_status   (o_status),
        .o_quantity (o_quantity),
        .o_value    (o_value),
        .o_report   (o_report),
        .o_last     (o_last)
    );

    a_hunt_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HUNT |-> !o_in_stall)
        else $error("stall while hunting");

    a_bank_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_sts.busy |-> emit_sts.bank != r_wbank)
        else $error("burst reads the bank being filled");

    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_last && o_value == '0 && !o_report))
        else $error("malformed error request");

    a_last_q: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last && o_status == ST_OK) |-> o_quantity == Q_LAST)
        else $error("burst ends early");

endmodule

`default_nettype wire
